// ----- hdl/rrmt_pkg.sv -----
// Package for the rename map table: sizes, command codes and controller state type.
// No dependencies; every other file in hdl imports it.
package rrmt_pkg;

  localparam int ARCH_REGS = 32;
  localparam int AIDX_W    = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;
  localparam int ARCH_W    = 5;
  localparam int PHYS_W    = 6;
  localparam int CMD_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_RENAME    = 2'd0,
    CMD_SET_READY = 2'd1,
    CMD_SWAP      = 2'd2,
    CMD_LOOKUP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HOLD  = 2'b10
  } ctl_state_e;

  // Controller to datapath: capture an input beat this cycle
  typedef struct packed {
    logic take;
  } dp_cmd_t;

endpackage

// ----- hdl/register_rename_map_table_top.sv -----
// Top level of the register rename map table: stream ports, controller and datapath.
// Depends on rrmt_pkg, rrmt_ctrl and rrmt_dpath.
//
//  channel  | direction | tdata (low bit up)                        | tuser
//  ---------+-----------+-------------------------------------------+------
//  s_axis   | in        | arch_reg[4:0], new_phys_reg, old_phys_reg | cmd
//  m_axis   | out       | phys_reg[5:0], ready_res                  | -
//
// One beat per cycle: the table is read and updated in the cycle a beat is
// accepted, and the result sits in the output register from the next cycle.
// Throughput is one beat per cycle while the sink keeps up.
// A stalled sink holds the result; a new beat is taken in the same cycle the
// held result drains. Reset maps entry i to physical register i, all ready.
module register_rename_map_table_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [4:0] arch_reg, [10:5] new_phys_reg, [16:11] old_phys_reg, [23:17] zero
  input  logic [rrmt_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [1:0] cmd
  input  logic [rrmt_pkg::CMD_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [5:0] phys_reg, [6] ready_res, [7] zero
  output logic [rrmt_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import rrmt_pkg::*;

  dp_cmd_t           dp_cmd;
  cmd_e              cmd;
  logic [PHYS_W-1:0] phys_reg;
  logic              ready_res;

  // Unpack the input beat
  assign cmd = cmd_e'(s_axis_tuser_i);

  rrmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .dp_cmd_o    (dp_cmd)
  );

  rrmt_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .cmd_i          (cmd),
    .arch_reg_i     (s_axis_tdata_i[ARCH_W-1:0]),
    .new_phys_reg_i (s_axis_tdata_i[ARCH_W+PHYS_W-1:ARCH_W]),
    .old_phys_reg_i (s_axis_tdata_i[ARCH_W+2*PHYS_W-1:ARCH_W+PHYS_W]),
    .phys_reg_o     (phys_reg),
    .ready_res_o    (ready_res)
  );

  // Pack the result beat, pad with zeros
  assign m_axis_tdata_o = {{(OUT_DATA_W-PHYS_W-1){1'b0}}, ready_res, phys_reg};

  // An accepted beat always leaves a result in the output register
  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.take |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  // Input side never stalls while the output register is empty
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  // A held result that is not taken and no new beat: result unchanged
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("held result changed");

endmodule

// ----- hdl/rrmt_ctrl.sv -----
// Handshake controller for the rename map table: tracks the output register.
// Depends on rrmt_pkg.
module rrmt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output rrmt_pkg::dp_cmd_t dp_cmd_o
);
  import rrmt_pkg::*;

  ctl_state_e state_q, state_d;
  logic       take;

  // Accept whenever the output register is empty or being drained
  assign in_ready_o    = (state_q == ST_EMPTY) || out_ready_i;
  assign take          = in_valid_i && in_ready_o;
  assign dp_cmd_o.take = take;
  assign out_valid_o   = (state_q == ST_HOLD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (take) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !take) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/rrmt_dpath.sv -----
// Datapath of the rename map table: map and ready flops, swap compare, result register.
// Depends on rrmt_pkg.
module rrmt_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrmt_pkg::dp_cmd_t           dp_cmd_i,
  input  rrmt_pkg::cmd_e              cmd_i,
  input  logic [rrmt_pkg::ARCH_W-1:0] arch_reg_i,
  input  logic [rrmt_pkg::PHYS_W-1:0] new_phys_reg_i,
  input  logic [rrmt_pkg::PHYS_W-1:0] old_phys_reg_i,
  output logic [rrmt_pkg::PHYS_W-1:0] phys_reg_o,
  output logic                        ready_res_o
);
  import rrmt_pkg::*;

  logic [PHYS_W-1:0] map_q   [ARCH_REGS];
  logic [ARCH_REGS-1:0] rdy_q;
  logic [AIDX_W-1:0] idx;
  logic              in_range;
  logic [PHYS_W-1:0] phys_res_q;
  logic              rdy_res_q;

  assign in_range = (32'(arch_reg_i) < ARCH_REGS);
  assign idx      = AIDX_W'(arch_reg_i);

  // Table update; swap compares every entry in parallel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ARCH_REGS; i++) begin
        map_q[i] <= PHYS_W'(i);
      end
      rdy_q <= '1;
    end else if (dp_cmd_i.take) begin
      case (cmd_i)
        CMD_RENAME: begin
          if (in_range) begin
            map_q[idx] <= new_phys_reg_i;
            rdy_q[idx] <= 1'b0;
          end
        end
        CMD_SET_READY: begin
          if (in_range) rdy_q[idx] <= 1'b1;
        end
        CMD_SWAP: begin
          for (int i = 0; i < ARCH_REGS; i++) begin
            if (map_q[i] == old_phys_reg_i) map_q[i] <= new_phys_reg_i;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: entry as it stood before the update
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.take) begin
      phys_res_q <= in_range ? map_q[idx] : '0;
      rdy_res_q  <= in_range ? rdy_q[idx] : 1'b0;
    end
  end

  assign phys_reg_o  = phys_res_q;
  assign ready_res_o = rdy_res_q;

endmodule

// ----- test/tb_register_rename_map_table_top.sv -----
// Self-checking bench for the register rename map table: stream driver, result monitor,
// and an in-bench map/ready-bit predictor fed by every accepted input beat.
// Depends on rrmt_pkg and register_rename_map_table_top.
module tb_register_rename_map_table_top;
  import rrmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    cmd_e              cmd;
    logic [ARCH_W-1:0] arch;
    logic [PHYS_W-1:0] new_phys;
    logic [PHYS_W-1:0] old_phys;
  } rename_op_t;

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              ready;
  } map_entry_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  rename_op_t pending_ops[$];
  map_entry_t expected_reads[$];

  // Predictor copy of the table
  logic [PHYS_W-1:0] phys_map_q[ARCH_REGS];
  logic              ready_q[ARCH_REGS];

  bit idle_on = 1'b1;
  int err_count = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int cmd_seen[4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;
  int tx_gap = 0;
  int rx_stall = 0;

  register_rename_map_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all while idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < ARCH_REGS; i++) begin
      phys_map_q[i] = PHYS_W'(i);
      ready_q[i]    = 1'b1;
    end
  endfunction

  // Return the entry as it stood before the beat, then apply the beat's update
  function automatic map_entry_t apply_map_op(rename_op_t op);
    map_entry_t prior;
    bit         in_range;
    in_range = (int'(op.arch) < ARCH_REGS);
    prior.phys  = in_range ? phys_map_q[op.arch] : '0;
    prior.ready = in_range ? ready_q[op.arch] : 1'b0;
    case (op.cmd)
      CMD_RENAME: begin
        if (in_range) begin
          phys_map_q[op.arch] = op.new_phys;
          ready_q[op.arch]    = 1'b0;
        end
      end
      CMD_SET_READY: begin
        if (in_range) ready_q[op.arch] = 1'b1;
      end
      CMD_SWAP: begin
        // All matching entries change at once; ready bits stay as they are
        for (int i = 0; i < ARCH_REGS; i++) begin
          if (phys_map_q[i] == op.old_phys) phys_map_q[i] = op.new_phys;
        end
      end
      default: ;
    endcase
    return prior;
  endfunction

  function automatic void queue_op(cmd_e cmd, int arch, int new_phys, int old_phys);
    rename_op_t op;
    op.cmd      = cmd;
    op.arch     = ARCH_W'(arch);
    op.new_phys = PHYS_W'(new_phys);
    op.old_phys = PHYS_W'(old_phys);
    pending_ops.push_back(op);
  endfunction

  // Rename-heavy traffic; swaps mostly search for numbers likely to be mapped
  function automatic void queue_random_ops(int count);
    int   r;
    cmd_e cmd;
    int   old_phys;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cmd = cmd_e'($urandom_range(0, 3));
        queue_op(cmd, $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35)      cmd = CMD_RENAME;
        else if (r < 60) cmd = CMD_SET_READY;
        else if (r < 78) cmd = CMD_SWAP;
        else             cmd = CMD_LOOKUP;
        old_phys = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 63);
        queue_op(cmd, $urandom_range(0, 31), $urandom_range(0, 63), old_phys);
      end
    end
  endfunction

  // Driver: present the next beat once the bus is free and any gap has run out
  always @(posedge clk_i or negedge rst_ni) begin : tx_side
    rename_op_t op;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      tx_gap   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - ARCH_W - 2 * PHYS_W){1'b0}},
                     op.old_phys, op.new_phys, op.arch};
        s_tuser  <= op.cmd;
        tx_gap   <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink: hold tready low for random stretches
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int n;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= 1'b0;
    end else begin
      n = pick_gap();
      if (n > 0) begin
        rx_stall <= n - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation, then
  // predict from the input beat taken at this edge
  always @(posedge clk_i) begin : monitor
    map_entry_t want;
    map_entry_t got;
    rename_op_t op;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.phys  = m_tdata[PHYS_W-1:0];
        got.ready = m_tdata[PHYS_W];
        if (expected_reads.size() == 0) begin
          err_count++;
          if (mismatch_count < MAX_REPORTS)
            $display("[%0t] unexpected result beat: phys_reg=%0d ready_res=%0b",
                     $realtime, got.phys, got.ready);
          mismatch_count++;
        end else begin
          want = expected_reads.pop_front();
          results_checked++;
          if (got.phys !== want.phys || got.ready !== want.ready) begin
            err_count++;
            if (mismatch_count < MAX_REPORTS)
              $display("[%0t] result %0d mismatch: phys_reg exp %0d got %0d, ready_res exp %0b got %0b",
                       $realtime, results_checked, want.phys, got.phys, want.ready, got.ready);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        op.cmd      = cmd_e'(s_tuser);
        op.arch     = s_tdata[ARCH_W-1:0];
        op.new_phys = s_tdata[ARCH_W +: PHYS_W];
        op.old_phys = s_tdata[ARCH_W + PHYS_W +: PHYS_W];
        cmd_seen[op.cmd]++;
        expected_reads.push_back(apply_map_op(op));
      end
    end
  end

  // Watchdog: give up when neither side has moved a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic drain_all();
    while (pending_ops.size() > 0 || s_tvalid || expected_reads.size() > 0)
      @(negedge clk_i);
  endtask

  initial begin
    reset_table();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset mapping at both ends, renames to extreme numbers,
    // set ready on a ready entry, multi-entry swap, swap with equal numbers,
    // swap that matches nothing, alternating bit patterns
    queue_op(CMD_LOOKUP,     0,  0,  0);
    queue_op(CMD_LOOKUP,    31, 63, 63);
    queue_op(CMD_RENAME,     0, 63,  0);
    queue_op(CMD_RENAME,    31,  0, 63);
    queue_op(CMD_LOOKUP,     0,  0,  0);
    queue_op(CMD_RENAME,     0, 42,  0);
    queue_op(CMD_SET_READY,  0,  0,  0);
    queue_op(CMD_SET_READY,  0, 63, 63);
    queue_op(CMD_SWAP,       0,  5, 42);
    queue_op(CMD_RENAME,     1,  5,  0);
    queue_op(CMD_RENAME,     2,  5,  0);
    queue_op(CMD_SWAP,       3, 17,  5);
    queue_op(CMD_LOOKUP,     5,  0,  0);
    queue_op(CMD_SWAP,       9, 17, 17);
    queue_op(CMD_SWAP,       0, 60, 61);
    queue_op(CMD_SWAP,      31, 63,  0);
    queue_op(CMD_LOOKUP,    31,  0,  0);
    queue_op(CMD_SET_READY,  1,  0,  0);
    queue_op(CMD_LOOKUP,     1,  0,  0);
    queue_op(CMD_RENAME,    21, 21, 42);
    queue_op(CMD_SWAP,      10, 42, 21);
    queue_op(CMD_RENAME,    31, 63, 63);
    queue_op(CMD_RENAME,     0,  0,  0);
    queue_op(CMD_LOOKUP,     2,  0,  0);
    drain_all();

    // Random traffic with idling on both sides, then flat out, then idling again
    queue_random_ops(600);
    drain_all();
    idle_on = 1'b0;
    queue_random_ops(300);
    drain_all();
    idle_on = 1'b1;
    queue_random_ops(300);
    drain_all();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (expected_reads.size() != 0) err_count++;

    $display("Sent %0d beats (%0d rename, %0d set-ready, %0d swap, %0d lookup)",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[CMD_RENAME], cmd_seen[CMD_SET_READY], cmd_seen[CMD_SWAP],
             cmd_seen[CMD_LOOKUP]);
    $display("Checked %0d result beats against the predicted table, %0d mismatched",
             results_checked, mismatch_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- register_rename_map_table_top.f -----
hdl/rrmt_pkg.sv
hdl/rrmt_ctrl.sv
hdl/rrmt_dpath.sv
hdl/register_rename_map_table_top.sv
test/tb_register_rename_map_table_top.sv
